// ----- hdl/sm4_ctr_keystream_cipher_assert.svh -----
// assertion helpers for the sm4 ctr keystream cipher
`ifndef SM4_CTR_KEYSTREAM_CIPHER_ASSERT_SVH
`define SM4_CTR_KEYSTREAM_CIPHER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SM4CTR_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SM4CTR_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

// ----- hdl/sm4ctr_pkg.sv -----
package sm4ctr_pkg;

   localparam int ROUNDS = 32;
   localparam int RK_AW = $clog2(ROUNDS);
   localparam int CSR_IW = 2;
   localparam int CSR_DW = 64;

   typedef logic [31:0] word_type;
   typedef logic [RK_AW-1:0] round_type;

   localparam round_type LAST_ROUND = RK_AW'(ROUNDS - 1);

   // register indexes of the csr port
   localparam logic [CSR_IW-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_KEY_LOW  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_IV_HIGH  = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_IV_LOW   = 2'd3;

   localparam word_type FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // operands of one pass through the shared round unit
   typedef struct packed {
      logic               key_sched;
      word_type [3:0]     x;
      word_type           rk;
   } rnd_req_type;

   // ck constant: byte j is (4*i + j) * 7 mod 256, byte 0 on top
   function automatic word_type ck_word(round_type idx);
      word_type w;
      logic [7:0] t;
      w = '0;
      for (int j = 0; j < 4; j++) begin
         t = 8'({idx, 2'(j)}) * 8'd7;
         w[31 - 8*j -: 8] = t;
      end
      return w;
   endfunction

endpackage

// ----- hdl/sm4ctr_req_if.sv -----
interface sm4ctr_req_if;
   logic        valid;
   logic        ready;
   logic        restart;
   logic [63:0] block_high;
   logic [63:0] block_low;
   logic [4:0]  valid_bytes;

   modport source (output valid, restart, block_high, block_low, valid_bytes, input ready);
   modport sink (input valid, restart, block_high, block_low, valid_bytes, output ready);
endinterface

// ----- hdl/sm4ctr_rsp_if.sv -----
interface sm4ctr_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] result_high;
   logic [63:0] result_low;

   modport source (output valid, result_high, result_low, input ready);
   modport sink (input valid, result_high, result_low, output ready);
endinterface

// ----- hdl/sm4ctr_round.sv -----
module sm4ctr_round
   import sm4ctr_pkg::*;
(
   input  rnd_req_type rnd_req,
   output word_type    rnd_word
);

   word_type mix;
   word_type sub;
   word_type lin;

   always_comb begin
      mix = rnd_req.x[1] ^ rnd_req.x[2] ^ rnd_req.x[3] ^ rnd_req.rk;
      for (int j = 0; j < 4; j++) begin
         sub[8*j +: 8] = SBOX[mix[8*j +: 8]];
      end
      if (rnd_req.key_sched) begin
         // key schedule map: rotations 13 and 23
         lin = sub ^ {sub[18:0], sub[31:19]} ^ {sub[8:0], sub[31:9]};
      end else begin
         // cipher map: rotations 2, 10, 18, 24
         lin = sub ^ {sub[29:0], sub[31:30]} ^ {sub[21:0], sub[31:22]}
                   ^ {sub[13:0], sub[31:14]} ^ {sub[7:0], sub[31:8]};
      end
      rnd_word = rnd_req.x[0] ^ lin;
   end

endmodule

// ----- hdl/sm4_ctr_keystream_cipher.sv -----
// flow: an accepted beat runs 32 key schedule rounds when restart is set, then
// one round key fetch, 32 cipher rounds and one xor/mask into the result register;
// the xor/mask waits until that register is free; a new beat is taken only in idle,
// so blocks do not overlap; the one shared round unit runs one round per cycle
// for key schedule and cipher alike
// reset: synchronous, active high; clears key, iv and counter to zero, empties
// the result register; round keys are undefined until the first restart
module sm4_ctr_keystream_cipher
   import sm4ctr_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   sm4ctr_req_if.sink          req_chan,
   sm4ctr_rsp_if.source        rsp_chan,
   input  logic                csr_wr_en,
   input  logic [CSR_IW-1:0]   csr_index,
   input  logic [CSR_DW-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KEY,
      ST_LOAD,
      ST_ENC,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   round_type       round_ff, round_in;
   word_type [3:0]  x_ff, x_in;
   logic [127:0]    counter_ff, counter_in;
   logic [127:0]    data_ff, data_in;
   logic [4:0]      vbytes_ff, vbytes_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [127:0]    result_ff, result_in;
   logic [63:0]     key_high_ff, key_low_ff, iv_high_ff, iv_low_ff;

   word_type        rk_mem [ROUNDS];
   word_type        rk_rd_ff;
   round_type       rk_addr;

   rnd_req_type     rnd_req;
   word_type        rnd_word;
   logic            req_fire;
   logic [15:0]     byte_keep;
   logic [127:0]    keep_mask;

   sm4ctr_round u_round (
      .rnd_req  (rnd_req),
      .rnd_word (rnd_word)
   );

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign req_fire             = req_chan.valid & req_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.result_high = result_ff[127:64];
   assign rsp_chan.result_low  = result_ff[63:0];

   always_comb begin
      rnd_req.key_sched = (state_ff == ST_KEY);
      rnd_req.x         = x_ff;
      rnd_req.rk        = (state_ff == ST_KEY) ? ck_word(round_ff) : rk_rd_ff;
      // prefetch the key of the next round; load fetches round 0
      rk_addr           = (state_ff == ST_ENC) ? round_ff + 1'b1 : '0;
   end

   // byte k is kept when k is below the valid count; counts above 16 keep all
   always_comb begin
      for (int k = 0; k < 16; k++) begin
         byte_keep[k]         = (5'(k) < vbytes_ff);
         keep_mask[127-8*k -: 8] = {8{byte_keep[k]}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      x_in         = x_ff;
      counter_in   = counter_ff;
      data_in      = data_ff;
      vbytes_in    = vbytes_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      result_in    = result_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               data_in   = {req_chan.block_high, req_chan.block_low};
               vbytes_in = req_chan.valid_bytes;
               round_in  = '0;
               if (req_chan.restart) begin
                  counter_in = {iv_high_ff, iv_low_ff};
                  x_in[0]    = key_high_ff[63:32] ^ FK[0];
                  x_in[1]    = key_high_ff[31:0] ^ FK[1];
                  x_in[2]    = key_low_ff[63:32] ^ FK[2];
                  x_in[3]    = key_low_ff[31:0] ^ FK[3];
                  state_in   = ST_KEY;
               end else begin
                  state_in   = ST_LOAD;
               end
            end
         end
         ST_KEY, ST_ENC: begin
            x_in     = {rnd_word, x_ff[3], x_ff[2], x_ff[1]};
            round_in = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               state_in = (state_ff == ST_KEY) ? ST_LOAD : ST_FINISH;
            end
         end
         ST_LOAD: begin
            x_in[0]  = counter_ff[127:96];
            x_in[1]  = counter_ff[95:64];
            x_in[2]  = counter_ff[63:32];
            x_in[3]  = counter_ff[31:0];
            round_in = '0;
            state_in = ST_ENC;
         end
         ST_FINISH: begin
            // wait until the result register is free or being emptied
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               result_in    = (data_ff ^ {x_ff[3], x_ff[2], x_ff[1], x_ff[0]}) & keep_mask;
               counter_in   = counter_ff + 128'd1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         round_ff     <= '0;
         counter_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         counter_ff   <= counter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff      <= x_in;
      data_ff   <= data_in;
      vbytes_ff <= vbytes_in;
      result_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
         iv_high_ff  <= '0;
         iv_low_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            CSR_IV_HIGH:  iv_high_ff  <= csr_wdata;
            CSR_IV_LOW:   iv_low_ff   <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // round key store: written during key schedule, read one round ahead
   always_ff @(posedge clock) begin
      if (state_ff == ST_KEY) begin
         rk_mem[round_ff] <= rnd_word;
      end
      rk_rd_ff <= rk_mem[rk_addr];
   end

`include "sm4_ctr_keystream_cipher_assert.svh"

   `SM4CTR_ASSERT_NEXT(a_busy_after_accept, req_fire, !req_chan.ready, "accepted beat did not start work")
   `SM4CTR_ASSERT_NEXT(a_enc_ends, state_ff == ST_ENC && round_ff == LAST_ROUND, state_ff == ST_FINISH, "cipher rounds did not end in finish")
   `SM4CTR_ASSERT_NEXT(a_key_ends, state_ff == ST_KEY && round_ff == LAST_ROUND, state_ff == ST_LOAD, "key schedule did not end in load")
   `SM4CTR_ASSERT_NOW(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH), "result appeared outside finish")

endmodule

// ----- tb/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sm4ctr_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int LONG_HOLD     = 600;
   localparam int SETTLE_CYCLES = 80;

   // published sm4 example: key and plaintext alike, and its ciphertext
   localparam logic [63:0] STD_KEY_HIGH = 64'h0123456789abcdef;
   localparam logic [63:0] STD_KEY_LOW  = 64'hfedcba9876543210;
   localparam logic [63:0] STD_CT_HIGH  = 64'h681edf34d206965e;
   localparam logic [63:0] STD_CT_LOW   = 64'h86b3e94f536e4246;

   localparam logic [31:0] SM4_FK [4] = '{32'hA3B1BAC6, 32'h56AA3350, 32'h677D9197, 32'hB27022DC};

   localparam logic [0:255][7:0] SM4_SBOX_BYTES = {
      128'hd690e9fe_cce13db7_16b614c2_28fb2c05,
      128'h2b679a76_2abe04c3_aa441326_49860699,
      128'h9c4250f4_91ef987a_33540b43_edcfac62,
      128'he4b31ca9_c908e895_80df94fa_758f3fa6,
      128'h4707a7fc_f37317ba_83593c19_e6854fa8,
      128'h686b81b2_7164da8b_f8eb0f4b_70569d35,
      128'h1e240e5e_6358d1a2_25227c3b_01217887,
      128'hd4004657_9fd32752_4c3602e7_a0c4c89e,
      128'heabf8ad2_40c738b5_a3f7f2ce_f96115a1,
      128'he0ae5da4_9b341a55_ad933230_f58cb1e3,
      128'h1df6e22e_8266ca60_c02923ab_0d534e6f,
      128'hd5db3745_defd8e2f_03ff6a72_6d6c5b51,
      128'h8d1baf92_bbddbc7f_11d95c41_1f105ad8,
      128'h0ac13188_a5cd7bbd_2d74d012_b8e5b4b0,
      128'h8969974a_0c96777e_65b9f109_c56ec684,
      128'h18f07dec_3adc4d20_79ee5f3e_d7cb3948
   };

   typedef struct {
      logic [63:0] high;
      logic [63:0] low;
   } cipher_words_type;

   typedef struct {
      bit          pinned;
      logic [63:0] high;
      logic [63:0] low;
   } sent_note_type;

   typedef struct packed {
      logic        restart;
      logic [63:0] data_high;
      logic [63:0] data_low;
      logic [4:0]  vbytes;
      logic        pinned;
      logic [63:0] want_high;
      logic [63:0] want_low;
   } directed_row_type;

   localparam directed_row_type DIRECTED [17] = '{
      '{1'b1, 64'h0, 64'h0, 5'd16, 1'b1, STD_CT_HIGH, STD_CT_LOW},
      '{1'b0, '1, '1, 5'd16, 1'b0, 64'h0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 5'd0, 1'b1, 64'h0, 64'h0},
      '{1'b0, STD_KEY_HIGH, STD_KEY_LOW, 5'd1, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 5'd7, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 5'd8, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 5'd9, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 5'd15, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 5'd17, 1'b0, 64'h0, 64'h0},
      '{1'b0, '1, '1, 5'd31, 1'b0, 64'h0, 64'h0},
      // restart reloads the counter, so the published vector comes back
      '{1'b1, 64'h0, 64'h0, 5'd16, 1'b1, STD_CT_HIGH, STD_CT_LOW},
      '{1'b0, {16{4'ha}}, {16{4'h5}}, 5'd16, 1'b0, 64'h0, 64'h0},
      '{1'b0, {16{4'h5}}, {16{4'ha}}, 5'd31, 1'b0, 64'h0, 64'h0},
      '{1'b1, '1, '1, 5'd0, 1'b1, 64'h0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 5'd16, 1'b0, 64'h0, 64'h0},
      // keystream xored onto itself
      '{1'b1, STD_CT_HIGH, STD_CT_LOW, 5'd16, 1'b1, 64'h0, 64'h0},
      '{1'b0, 64'h0, 64'h0, 5'd2, 1'b0, 64'h0, 64'h0}
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [CSR_IW-1:0]   csr_index;
   logic [CSR_DW-1:0]   csr_wdata;

   sm4ctr_req_if req_chan ();
   sm4ctr_rsp_if rsp_chan ();

   sm4_ctr_keystream_cipher u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow of the block's registers and state
   logic [63:0]  sh_key_high, sh_key_low, sh_iv_high, sh_iv_low;
   logic [127:0] sh_counter;
   logic [31:0]  sh_round_keys [32];

   sent_note_type    sent_q [$];
   cipher_words_type cipher_due_q [$];

   int mismatch_count = 0;
   int cycle_count = 0;
   int tx_idle_pct;
   int rx_stall_pct;
   int hold_requests;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [31:0] rotl32(logic [31:0] x, int n);
      return (x << n) | (x >> (32 - n));
   endfunction

   function automatic logic [31:0] sbox_word(logic [31:0] x);
      return {SM4_SBOX_BYTES[x[31:24]], SM4_SBOX_BYTES[x[23:16]],
              SM4_SBOX_BYTES[x[15:8]], SM4_SBOX_BYTES[x[7:0]]};
   endfunction

   function automatic logic [31:0] ck_const(int i);
      logic [31:0] w;
      w = '0;
      for (int j = 0; j < 4; j++)
         w = {w[23:0], 8'((4 * i + j) * 7)};
      return w;
   endfunction

   function automatic void expand_round_keys();
      logic [31:0] k [4];
      logic [31:0] b, n;
      k[0] = sh_key_high[63:32] ^ SM4_FK[0];
      k[1] = sh_key_high[31:0] ^ SM4_FK[1];
      k[2] = sh_key_low[63:32] ^ SM4_FK[2];
      k[3] = sh_key_low[31:0] ^ SM4_FK[3];
      for (int i = 0; i < 32; i++) begin
         b = sbox_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
         n = k[0] ^ b ^ rotl32(b, 13) ^ rotl32(b, 23);
         sh_round_keys[i] = n;
         k[0] = k[1];
         k[1] = k[2];
         k[2] = k[3];
         k[3] = n;
      end
   endfunction

   function automatic logic [127:0] sm4_encrypt_block(logic [127:0] blk);
      logic [31:0] x [4];
      logic [31:0] b, n;
      x[0] = blk[127:96];
      x[1] = blk[95:64];
      x[2] = blk[63:32];
      x[3] = blk[31:0];
      for (int i = 0; i < 32; i++) begin
         b = sbox_word(x[1] ^ x[2] ^ x[3] ^ sh_round_keys[i]);
         n = x[0] ^ b ^ rotl32(b, 2) ^ rotl32(b, 10) ^ rotl32(b, 18) ^ rotl32(b, 24);
         x[0] = x[1];
         x[1] = x[2];
         x[2] = x[3];
         x[3] = n;
      end
      return {x[3], x[2], x[1], x[0]};
   endfunction

   // one ctr block: on restart reloads the counter and expands the round keys; advances the shadow counter
   function automatic cipher_words_type predict_ctr_beat(logic restart, logic [127:0] data,
                                                         logic [4:0] vbytes);
      cipher_words_type res;
      logic [127:0]     keep, outw;
      int               n;
      if (restart) begin
         sh_counter = {sh_iv_high, sh_iv_low};
         expand_round_keys();
      end
      n = (vbytes > 5'd16) ? 16 : int'(vbytes);
      keep = (n == 0) ? '0 : ({128{1'b1}} << (8 * (16 - n)));
      outw = (data ^ sm4_encrypt_block(sh_counter)) & keep;
      sh_counter = sh_counter + 128'd1;
      res.high = outw[127:64];
      res.low = outw[63:0];
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : beat_monitor
      sent_note_type    note;
      cipher_words_type want;
      if (reset) begin
         sh_key_high = '0;
         sh_key_low = '0;
         sh_iv_high = '0;
         sh_iv_low = '0;
         sh_counter = '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_KEY_HIGH: sh_key_high = csr_wdata;
               CSR_KEY_LOW:  sh_key_low = csr_wdata;
               CSR_IV_HIGH:  sh_iv_high = csr_wdata;
               CSR_IV_LOW:   sh_iv_low = csr_wdata;
               default: ;
            endcase
         end
         if (req_chan.valid && req_chan.ready) begin
            note = sent_q.pop_front();
            want = predict_ctr_beat(req_chan.restart,
                                    {req_chan.block_high, req_chan.block_low},
                                    req_chan.valid_bytes);
            if (note.pinned) begin
               want.high = note.high;
               want.low = note.low;
            end
            cipher_due_q.push_back(want);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (cipher_due_q.size() == 0) begin
               report_mismatch("result beat with nothing pending", rsp_chan.result_high, '0);
            end else begin
               want = cipher_due_q.pop_front();
               if (rsp_chan.result_high !== want.high)
                  report_mismatch("result_high", rsp_chan.result_high, want.high);
               if (rsp_chan.result_low !== want.low)
                  report_mismatch("result_low", rsp_chan.result_low, want.low);
            end
         end
      end
   end

   initial begin : rsp_sink
      int hold_left;
      int hold_served;
      hold_left = 0;
      hold_served = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rx_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("sm4_ctr_keystream_cipher verification failed");
         $finish;
      end
   end

   task automatic drive_beat(logic restart, logic [63:0] data_high, logic [63:0] data_low,
                             logic [4:0] vbytes, bit pinned, logic [63:0] want_high,
                             logic [63:0] want_low);
      sent_note_type note;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      note.pinned = pinned;
      note.high = want_high;
      note.low = want_low;
      sent_q.push_back(note);
      req_chan.valid <= 1'b1;
      req_chan.restart <= restart;
      req_chan.block_high <= data_high;
      req_chan.block_low <= data_low;
      req_chan.valid_bytes <= vbytes;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drain();
      req_chan.valid <= 1'b0;
      while (sent_q.size() != 0 || cipher_due_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_cipher_config(logic [63:0] key_high, logic [63:0] key_low,
                                    logic [63:0] iv_high, logic [63:0] iv_low);
      wait_drain();
      csr_wr_en <= 1'b1;
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= key_high;
      @(posedge clock);
      csr_index <= CSR_KEY_LOW;
      csr_wdata <= key_low;
      @(posedge clock);
      csr_index <= CSR_IV_HIGH;
      csr_wdata <= iv_high;
      @(posedge clock);
      csr_index <= CSR_IV_LOW;
      csr_wdata <= iv_low;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // messages: optional restart, full blocks, a short final block; some odd counts
   task automatic run_messages(int beats);
      int         msg_left;
      logic       restart;
      logic [4:0] vbytes;
      msg_left = 0;
      repeat (beats) begin
         restart = 1'b0;
         if (msg_left == 0) begin
            msg_left = $urandom_range(1, 12);
            restart = ($urandom_range(3) != 0);
         end
         vbytes = (msg_left == 1) ? 5'($urandom_range(1, 16)) : 5'd16;
         if ($urandom_range(9) == 0)
            vbytes = 5'($urandom_range(0, 31));
         drive_beat(restart, rand64(), rand64(), vbytes, 1'b0, '0, '0);
         msg_left--;
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_KEY_HIGH;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.restart <= 1'b0;
      req_chan.block_high <= '0;
      req_chan.block_low <= '0;
      req_chan.valid_bytes <= 5'd16;
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      hold_requests <= 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      set_cipher_config(STD_KEY_HIGH, STD_KEY_LOW, STD_KEY_HIGH, STD_KEY_LOW);
      foreach (DIRECTED[i])
         drive_beat(DIRECTED[i].restart, DIRECTED[i].data_high, DIRECTED[i].data_low,
                    DIRECTED[i].vbytes, DIRECTED[i].pinned, DIRECTED[i].want_high,
                    DIRECTED[i].want_low);

      set_cipher_config(rand64(), rand64(), rand64(), rand64());
      run_messages(140);

      // all-ones iv wraps the whole counter after one block
      set_cipher_config('1, '1, '1, '1);
      tx_idle_pct = 67;
      run_messages(140);

      set_cipher_config('0, '0, rand64(), 64'hFFFF_FFFF_FFFF_FFFD);
      tx_idle_pct = 0;
      rx_stall_pct <= 67;
      run_messages(140);

      set_cipher_config(rand64(), rand64(), rand64(), rand64());
      tx_idle_pct = 31;
      rx_stall_pct <= 31;
      run_messages(140);

      // receiver holds off while beats keep coming, so the input backs up
      set_cipher_config(rand64(), rand64(), rand64(), rand64());
      tx_idle_pct = 0;
      rx_stall_pct <= 0;
      hold_requests <= hold_requests + 1;
      run_messages(60);

      set_cipher_config('1, rand64(), '0, '0);
      tx_idle_pct = 31;
      rx_stall_pct <= 31;
      run_messages(160);

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("sm4_ctr_keystream_cipher verification clean");
      else
         $display("sm4_ctr_keystream_cipher verification failed");
      $finish;
   end

endmodule
